/* rtl/core/ilid_pkg.sv */
// Shared constants, codes and controller-to-datapath types for the indexed list unit.
`timescale 1ns / 1ps

package ilid_pkg;

    // List geometry.
    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the request and result beats.
    localparam int OP_W    = 2;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;

    // Derived widths: entry address, entry count, and index compare width.
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Position selection codes; the remaining code is rejected.
    localparam logic [MODE_W-1:0] WM_INDEX = 2'd0;
    localparam logic [MODE_W-1:0] WM_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] WM_END   = 2'd2;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // Register the request beat.
        logic execute;   // Apply the registered request and load the result.
    } t_dp_cmd;

endpackage

/* rtl/core/ilid_ctrl.sv */
// Controller state machine for the indexed list unit: handshakes and sequencing.
`timescale 1ns / 1ps

module ilid_ctrl
    import ilid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // The result register is free when empty or when its beat leaves this cycle.
    // No request beat is taken while reset is held.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.execute = (r_state == S_EXEC) && slot_free;

    // Next state and result valid.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.execute) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted request always moves to execution and blocks the input.
    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("accepted request did not enter execution");

    // Execution always presents a result beat in the next cycle.
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> o_out_valid)
        else $error("executed request produced no result beat");

    // A stalled result keeps the pending request waiting.
    a_stall_holds_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && r_out_valid && !i_out_ready |=> (r_state == S_EXEC))
        else $error("request executed while result register was occupied");

endmodule

/* rtl/core/ilid_datapath.sv */
// Datapath of the indexed list unit: entry array, count, request and result registers.
`timescale 1ns / 1ps

module ilid_datapath
    import ilid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic        [OP_W-1:0]    i_op,
    input  logic        [MODE_W-1:0]  i_where_mode,
    input  logic        [POS_W-1:0]   i_position,
    input  logic signed [VALUE_W-1:0] i_item_value,
    output logic        [STAT_W-1:0]  o_status,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic        [ECNT_W-1:0]  o_entry_count
);

    // Request registers.
    t_op                r_op;
    logic [MODE_W-1:0]  r_mode;
    logic [POS_W-1:0]   r_pos;
    logic [VALUE_W-1:0] r_val;

    // List state.
    logic [WORD_BITS-1:0] r_entries [CAPACITY];
    logic [WORD_BITS-1:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]     r_count, n_count;

    // Result registers.
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_rd, n_rd;

    logic [CMP_W-1:0]     tgt;
    logic [CMP_W-1:0]     cnt_x;
    logic [WORD_BITS-1:0] wr_word;

    assign cnt_x   = CMP_W'(r_count);
    assign wr_word = WORD_BITS'(r_val);

    // Target index: front is zero, end is count for insert and count-1 otherwise.
    always_comb begin
        case (r_mode)
            WM_INDEX: tgt = CMP_W'(r_pos);
            WM_FRONT: tgt = '0;
            WM_END:   tgt = (r_op == OP_INSERT) ? cnt_x : cnt_x - CMP_W'(1);
            default:  tgt = '0;
        endcase
    end

    // Request evaluation with parallel shift of the entry array.
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_status  = ST_OK;
        n_rd      = '0;
        if (!(r_mode inside {WM_INDEX, WM_FRONT, WM_END})) begin
            n_status = ST_BAD_INDEX;
        end else if (r_op == OP_INSERT) begin
            if (tgt > cnt_x) begin
                n_status = ST_BAD_INDEX;
            end else if (r_count >= CNT_W'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                for (int i = 1; i < CAPACITY; i++) begin
                    if ((CMP_W'(i) > tgt) && (CMP_W'(i) <= cnt_x)) begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
                n_entries[tgt[ADDR_W-1:0]] = wr_word;
                n_count = r_count + CNT_W'(1);
            end
        end else if ((r_mode != WM_INDEX) && (r_count == '0)) begin
            n_status = ST_EMPTY;
        end else if (tgt >= cnt_x) begin
            n_status = ST_BAD_INDEX;
        end else begin
            case (r_op)
                OP_DELETE: begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if ((CMP_W'(i) >= tgt) && (CMP_W'(i + 1) < cnt_x)) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
                OP_UPDATE: begin
                    n_entries[tgt[ADDR_W-1:0]] = wr_word;
                end
                OP_READ: begin
                    n_rd = VALUE_W'(r_entries[tgt[ADDR_W-1:0]]);
                end
                default: begin
                    n_status = ST_BAD_INDEX;
                end
            endcase
        end
    end

    // Request capture on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_mode <= i_where_mode;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
    end

    // Entry array and result payload, loaded on execution.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_entries <= n_entries;
            r_status  <= n_status;
            r_rd      <= n_rd;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_entry_count = ECNT_W'(r_count);

endmodule

/* rtl/core/indexed_list_insert_delete_unit.sv */
// A request beat is captured, then executes once the output register is free;
// its result is registered then. No new request is taken until the previous one has executed.
// A new request is accepted while the previous result still waits in the output register.
// Execution waits only while that output register is still occupied.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_insert_delete_unit
    import ilid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic        [OP_W-1:0]    i_op,
    input  logic        [MODE_W-1:0]  i_where_mode,
    input  logic        [POS_W-1:0]   i_position,
    input  logic signed [VALUE_W-1:0] i_item_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic        [STAT_W-1:0]  o_status,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic        [ECNT_W-1:0]  o_entry_count
);

    t_dp_cmd cmd;

    // Handshake and sequencing.
    ilid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // List storage and request evaluation.
    ilid_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_where_mode  (i_where_mode),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

endmodule
